// ===== design/des_pkg.sv =====
// shared types, constants and helpers for the dyad event statistics block
// depends on nothing; used by des_store, the top level and the checker
package des_pkg;

   // sizing
   localparam int ACTORS      = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int ACTOR_W     = 4;
   localparam int INDEX_W     = 16;
   localparam int FIELD_W     = 16;
   localparam int PAIRS       = ACTORS * ACTORS;
   localparam int ADDR_W      = $clog2(PAIRS);

   // pattern codes
   localparam logic [2:0] SC_NONE = 3'd0;
   localparam logic [2:0] SC_ABBA = 3'd1;
   localparam logic [2:0] SC_ABBY = 3'd2;
   localparam logic [2:0] SC_ABXA = 3'd3;
   localparam logic [2:0] SC_ABXB = 3'd4;
   localparam logic [2:0] SC_ABAY = 3'd5;
   localparam logic [2:0] SC_ABAB = 3'd6;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [ADDR_W-1:0]      addr_type;
   typedef logic [ACTOR_W-1:0]     actor_type;

   // one statistics record per ordered pair
   typedef struct packed {
      logic [2:0]         shift_code;
      count_type          from_sent;
      count_type          to_sent;
      count_type          from_received;
      count_type          to_received;
      count_type          repeat_count;
      logic [INDEX_W-1:0] last_change;
   } record_type;

   // store access, one read and one write port
   typedef struct packed {
      logic     en;
      addr_type addr;
   } rd_req_type;

   typedef struct packed {
      logic       en;
      addr_type   addr;
      record_type data;
   } wr_req_type;

   // flat entry index of the ordered pair (i, j)
   function automatic addr_type pair_addr(actor_type i, actor_type j);
      logic [31:0] flat;
      flat = 32'(i) * 32'(ACTORS) + 32'(j);
      return flat[ADDR_W-1:0];
   endfunction

   // saturating increment
   function automatic count_type sat_inc(count_type v);
      return (v == '1) ? v : count_type'(v + 1'b1);
   endfunction

   // low bits of a counter as shown on a result field
   function automatic logic [FIELD_W-1:0] to_field(count_type v);
      logic [31:0] wide;
      wide = 32'(v);
      return wide[FIELD_W-1:0];
   endfunction

endpackage

// ===== design/des_store.sv =====
// pair statistics memory: one record per ordered pair, registered read data
// depends on des_pkg; entries not yet written since reset read as zero
module des_store (
   input  logic                   clock,
   input  logic                   reset,
   input  des_pkg::rd_req_type    rd_req,
   input  des_pkg::wr_req_type    wr_req,
   output des_pkg::record_type    rd_data
);

   des_pkg::record_type mem [des_pkg::PAIRS];
   logic [des_pkg::PAIRS-1:0] written_ff;
   des_pkg::record_type rd_data_ff;
   logic rd_written_ff;

   // record array, no reset
   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.addr] <= wr_req.data;
      end
      if (rd_req.en) begin
         rd_data_ff <= mem[rd_req.addr];
      end
   end

   // written flags, cleared at once by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (wr_req.en) begin
            written_ff[wr_req.addr] <= 1'b1;
         end
         if (rd_req.en) begin
            rd_written_ff <= written_ff[rd_req.addr];
         end
      end
   end

   // unwritten entry reads as the reset value
   assign rd_data = rd_written_ff ? rd_data_ff : '0;

endmodule

// ===== design/dyad_event_statistics_update.sv =====
// top level of the dyad event statistics block: pair sequencer, record update
// depends on des_pkg and des_store
//
// Usage: an event beat on req_ (sender, receiver, event index) refreshes every
// ordered pair that shares an actor with the event, self pairs apart. For each
// other actor r in rising order the pairs (a,r), (r,a), (b,r), (r,b) come out,
// then (a,b) and last (b,a) with rsp_final_of_run high: 58 result beats for 16
// actors. Each result beat carries the pair's statistics after the refresh.
// A self event or an actor out of range is taken and yields no result.
// Order: the first result passes from the sequencer through the read stage to
// the result register; a walk that starts on an event actor skips it first.
// Rate: one pair per cycle, one memory read-modify-write each, while rsp_ready
// stays high; besides the pairs the walk passes over the two event actors,
// drains the read stage and takes the next event.
// The next event is taken once the last pair has left the read stage, while
// the final result may still wait.
// A low rsp_ready holds the result register and the one pair in the read
// stage; the sequencer stops issuing reads until a slot frees up.
// Reset: synchronous, active high; the whole table reads as zero afterwards
// and both channels come up empty.
module dyad_event_statistics_update (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_event_sender,
   input  logic [3:0]  req_event_receiver,
   input  logic [15:0] req_event_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_pair_from,
   output logic [3:0]  rsp_pair_to,
   output logic [2:0]  rsp_shift_code,
   output logic [15:0] rsp_from_sent_total,
   output logic [15:0] rsp_to_sent_total,
   output logic [15:0] rsp_from_received_total,
   output logic [15:0] rsp_to_received_total,
   output logic [15:0] rsp_repeat_total,
   output logic [15:0] rsp_last_change,
   output logic        rsp_final_of_run
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RING,
      ST_AB,
      ST_BA
   } state_type;

   state_type state_ff, state_in;
   des_pkg::actor_type a_ff, a_in, b_ff, b_in, r_ff, r_in;
   logic [1:0] sub_ff, sub_in;
   logic [des_pkg::INDEX_W-1:0] m_ff, m_in;

   // read stage
   logic pend_ff, pend_in, pend_last_ff, pend_last_in;
   des_pkg::actor_type pend_i_ff, pend_i_in, pend_j_ff, pend_j_in;

   // result register
   logic out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   des_pkg::actor_type out_i_ff, out_i_in, out_j_ff, out_j_in;
   des_pkg::record_type out_rec_ff, out_rec_in;

   des_pkg::rd_req_type rd_req;
   des_pkg::wr_req_type wr_req;
   des_pkg::record_type rd_rec, new_rec;

   logic req_take, event_ok, pend_move, slot_free, issue, skip, r_last;
   des_pkg::actor_type iss_i, iss_j;
   logic [2:0] code;

   des_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_req  (rd_req),
      .wr_req  (wr_req),
      .rd_data (rd_rec)
   );

   // handshake and slot bookkeeping
   assign req_ready = (state_ff == ST_IDLE) && !pend_ff;
   assign req_take  = req_valid && req_ready;
   assign event_ok  = (req_event_sender != req_event_receiver)
                      && (32'(req_event_sender) < des_pkg::ACTORS)
                      && (32'(req_event_receiver) < des_pkg::ACTORS);
   assign pend_move = pend_ff && (!out_valid_ff || rsp_ready);
   assign slot_free = !pend_ff || pend_move;
   assign skip      = (r_ff == a_ff) || (r_ff == b_ff);
   assign r_last    = (r_ff == des_pkg::actor_type'(des_pkg::ACTORS - 1));

   // pair to read this cycle
   always_comb begin
      issue = 1'b0;
      iss_i = a_ff;
      iss_j = b_ff;
      case (state_ff)
         ST_RING: begin
            issue = slot_free && !skip;
            case (sub_ff)
               2'd0:    begin iss_i = a_ff; iss_j = r_ff; end
               2'd1:    begin iss_i = r_ff; iss_j = a_ff; end
               2'd2:    begin iss_i = b_ff; iss_j = r_ff; end
               default: begin iss_i = r_ff; iss_j = b_ff; end
            endcase
         end
         ST_AB: begin
            issue = slot_free;
         end
         ST_BA: begin
            issue = slot_free;
            iss_i = b_ff;
            iss_j = a_ff;
         end
         default: begin
            issue = 1'b0;
         end
      endcase
   end

   // record update for the pair in the read stage
   always_comb begin
      if (pend_i_ff == b_ff && pend_j_ff == a_ff) begin
         code = des_pkg::SC_ABBA;
      end else if (pend_i_ff == b_ff) begin
         code = des_pkg::SC_ABBY;
      end else if (pend_i_ff != a_ff && pend_j_ff == a_ff) begin
         code = des_pkg::SC_ABXA;
      end else if (pend_i_ff != a_ff && pend_j_ff == b_ff) begin
         code = des_pkg::SC_ABXB;
      end else if (pend_i_ff == a_ff && pend_j_ff != b_ff) begin
         code = des_pkg::SC_ABAY;
      end else begin
         code = des_pkg::SC_ABAB;
      end
      new_rec = rd_rec;
      new_rec.shift_code = code;
      if (pend_i_ff == a_ff) new_rec.from_sent = des_pkg::sat_inc(rd_rec.from_sent);
      if (pend_j_ff == a_ff) new_rec.to_sent = des_pkg::sat_inc(rd_rec.to_sent);
      if (pend_i_ff == b_ff) begin
         new_rec.from_received = des_pkg::sat_inc(rd_rec.from_received);
      end
      if (pend_j_ff == b_ff) begin
         new_rec.to_received = des_pkg::sat_inc(rd_rec.to_received);
      end
      if (pend_i_ff == a_ff && pend_j_ff == b_ff) begin
         new_rec.repeat_count = des_pkg::sat_inc(rd_rec.repeat_count);
      end
      new_rec.last_change = m_ff;
   end

   // store ports
   always_comb begin
      rd_req.en   = issue;
      rd_req.addr = des_pkg::pair_addr(iss_i, iss_j);
      wr_req.en   = pend_move;
      wr_req.addr = des_pkg::pair_addr(pend_i_ff, pend_j_ff);
      wr_req.data = new_rec;
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      m_in         = m_ff;
      r_in         = r_ff;
      sub_in       = sub_ff;
      pend_in      = pend_ff;
      pend_i_in    = pend_i_ff;
      pend_j_in    = pend_j_ff;
      pend_last_in = pend_last_ff;
      out_valid_in = out_valid_ff;
      out_last_in  = out_last_ff;
      out_i_in     = out_i_ff;
      out_j_in     = out_j_ff;
      out_rec_in   = out_rec_ff;

      // sequencer
      case (state_ff)
         ST_IDLE: begin
            if (req_take && event_ok) begin
               state_in = ST_RING;
               a_in     = req_event_sender;
               b_in     = req_event_receiver;
               m_in     = req_event_index;
               r_in     = '0;
               sub_in   = '0;
            end
         end
         ST_RING: begin
            if (skip || (issue && sub_ff == 2'd3)) begin
               sub_in = '0;
               if (r_last) begin
                  state_in = ST_AB;
               end else begin
                  r_in = r_ff + 1'b1;
               end
            end else if (issue) begin
               sub_in = sub_ff + 1'b1;
            end
         end
         ST_AB: begin
            if (issue) state_in = ST_BA;
         end
         ST_BA: begin
            if (issue) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // read stage
      if (issue) begin
         pend_in      = 1'b1;
         pend_i_in    = iss_i;
         pend_j_in    = iss_j;
         pend_last_in = (state_ff == ST_BA);
      end else if (pend_move) begin
         pend_in = 1'b0;
      end

      // result register
      if (pend_move) begin
         out_valid_in = 1'b1;
         out_last_in  = pend_last_ff;
         out_i_in     = pend_i_ff;
         out_j_in     = pend_j_ff;
         out_rec_in   = new_rec;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      a_ff         <= a_in;
      b_ff         <= b_in;
      m_ff         <= m_in;
      r_ff         <= r_in;
      sub_ff       <= sub_in;
      pend_i_ff    <= pend_i_in;
      pend_j_ff    <= pend_j_in;
      pend_last_ff <= pend_last_in;
      out_last_ff  <= out_last_in;
      out_i_ff     <= out_i_in;
      out_j_ff     <= out_j_in;
      out_rec_ff   <= out_rec_in;
   end

   // result beat
   assign rsp_valid               = out_valid_ff;
   assign rsp_pair_from           = out_i_ff;
   assign rsp_pair_to             = out_j_ff;
   assign rsp_shift_code          = out_rec_ff.shift_code;
   assign rsp_from_sent_total     = des_pkg::to_field(out_rec_ff.from_sent);
   assign rsp_to_sent_total       = des_pkg::to_field(out_rec_ff.to_sent);
   assign rsp_from_received_total = des_pkg::to_field(out_rec_ff.from_received);
   assign rsp_to_received_total   = des_pkg::to_field(out_rec_ff.to_received);
   assign rsp_repeat_total        = des_pkg::to_field(out_rec_ff.repeat_count);
   assign rsp_last_change         = out_rec_ff.last_change;
   assign rsp_final_of_run        = out_last_ff;

endmodule

// ===== design/des_checker.sv =====
// port-level checks for the dyad event statistics block, bound to the top level
// depends on des_pkg and dyad_event_statistics_update
module des_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [3:0]  req_event_sender,
   input logic [3:0]  req_event_receiver,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_pair_from,
   input logic [3:0]  rsp_pair_to,
   input logic [2:0]  rsp_shift_code,
   input logic [15:0] rsp_last_change,
   input logic        rsp_final_of_run
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pair_from)
         && $stable(rsp_pair_to) && $stable(rsp_last_change))
      else $error("stalled result beat changed");

   // a real event blocks the request side right after it is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_event_sender != req_event_receiver)
         && (32'(req_event_sender) < des_pkg::ACTORS)
         && (32'(req_event_receiver) < des_pkg::ACTORS)
      |=> !req_ready)
      else $error("event taken while another was in flight");

   // no new event while a run still has results to come
   a_run_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_of_run |-> !req_ready)
      else $error("request side open in the middle of a run");

   // refreshed pairs are never self pairs
   a_no_self: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pair_from != rsp_pair_to)
      else $error("self pair in a result beat");

   // the run closes on the reversed pair
   a_final_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_of_run |-> rsp_shift_code == des_pkg::SC_ABBA)
      else $error("last beat of a run is not the reversed pair");

endmodule

bind dyad_event_statistics_update des_checker u_des_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_event_sender   (req_event_sender),
   .req_event_receiver (req_event_receiver),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_pair_from      (rsp_pair_from),
   .rsp_pair_to        (rsp_pair_to),
   .rsp_shift_code     (rsp_shift_code),
   .rsp_last_change    (rsp_last_change),
   .rsp_final_of_run   (rsp_final_of_run)
);

// ===== bench/dyad_event_statistics_update_tb.sv =====
// self-checking bench for dyad_event_statistics_update: directed and random events
// checked against an in-bench pair-statistics predictor; depends on des_pkg and the rtl
module dyad_event_statistics_update_tb;

   // one expected or observed result beat
   typedef struct packed {
      des_pkg::actor_type pair_from;
      des_pkg::actor_type pair_to;
      logic [2:0]         shift_code;
      logic [15:0]        from_sent;
      logic [15:0]        to_sent;
      logic [15:0]        from_received;
      logic [15:0]        to_received;
      logic [15:0]        repeat_cnt;
      logic [15:0]        last_change;
      logic               last_of_event;
   } stats_beat_type;

   // one event beat, optionally with its final result typed in
   typedef struct {
      des_pkg::actor_type sender;
      des_pkg::actor_type receiver;
      logic [15:0]        index;
      bit                 typed;
      stats_beat_type     final_beat;
   } event_item_type;

   typedef enum int unsigned {
      FLOW_OPEN,
      FLOW_HALF,
      FLOW_SPARSE,
      FLOW_COMB
   } flow_mode_type;

   localparam int             DIR_N         = 20;
   localparam int             RANDOM_EVENTS = 100;
   localparam int unsigned    HOLD_CYCLES   = 600;
   localparam stats_beat_type NO_BEAT       = '0;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [3:0]  req_event_sender;
   logic [3:0]  req_event_receiver;
   logic [15:0] req_event_index;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_pair_from;
   logic [3:0]  rsp_pair_to;
   logic [2:0]  rsp_shift_code;
   logic [15:0] rsp_from_sent_total;
   logic [15:0] rsp_to_sent_total;
   logic [15:0] rsp_from_received_total;
   logic [15:0] rsp_to_received_total;
   logic [15:0] rsp_repeat_total;
   logic [15:0] rsp_last_change;
   logic        rsp_final_of_run;

   // predictor state, one entry per ordered pair, all zero after reset
   logic [2:0]         code_tab          [des_pkg::PAIRS] = '{default: des_pkg::SC_NONE};
   des_pkg::count_type from_sent_tab     [des_pkg::PAIRS] = '{default: '0};
   des_pkg::count_type to_sent_tab       [des_pkg::PAIRS] = '{default: '0};
   des_pkg::count_type from_received_tab [des_pkg::PAIRS] = '{default: '0};
   des_pkg::count_type to_received_tab   [des_pkg::PAIRS] = '{default: '0};
   des_pkg::count_type repeat_tab        [des_pkg::PAIRS] = '{default: '0};
   logic [15:0]        change_tab        [des_pkg::PAIRS] = '{default: '0};

   event_item_type event_q[$];
   event_item_type directed_rows [DIR_N];
   stats_beat_type pending_stats[$];
   bit             offered_typed;
   stats_beat_type offered_beat;
   int             events_taken = 0;
   int             total_events;
   int             mismatch_count = 0;

   dyad_event_statistics_update u_top (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_event_sender        (req_event_sender),
      .req_event_receiver      (req_event_receiver),
      .req_event_index         (req_event_index),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_pair_from           (rsp_pair_from),
      .rsp_pair_to             (rsp_pair_to),
      .rsp_shift_code          (rsp_shift_code),
      .rsp_from_sent_total     (rsp_from_sent_total),
      .rsp_to_sent_total       (rsp_to_sent_total),
      .rsp_from_received_total (rsp_from_received_total),
      .rsp_to_received_total   (rsp_to_received_total),
      .rsp_repeat_total        (rsp_repeat_total),
      .rsp_last_change         (rsp_last_change),
      .rsp_final_of_run        (rsp_final_of_run)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // append an expected beat at the tail
   function automatic void queue_beat(stats_beat_type b);
      pending_stats.insert(pending_stats.size(), b);
   endfunction

   // append an event at the tail of the stimulus list
   function automatic void queue_event(event_item_type e);
      event_q.insert(event_q.size(), e);
   endfunction

   // counter that sticks at all ones
   function automatic des_pkg::count_type count_up(des_pkg::count_type v);
      des_pkg::count_type top;
      top = {des_pkg::COUNT_WIDTH{1'b1}};
      if (v == top)
         return v;
      return v + des_pkg::count_type'(1);
   endfunction

   // refresh one ordered pair (i, j) for event a -> b and return its beat
   function automatic stats_beat_type refresh_pair(des_pkg::actor_type a,
                                                   des_pkg::actor_type b,
                                                   logic [15:0] m,
                                                   des_pkg::actor_type i,
                                                   des_pkg::actor_type j,
                                                   bit last);
      int             k;
      stats_beat_type beat;
      k = int'(i) * des_pkg::ACTORS + int'(j);
      if (i == b && j == a)      code_tab[k] = des_pkg::SC_ABBA;
      else if (i == b)           code_tab[k] = des_pkg::SC_ABBY;
      else if (i != a && j == a) code_tab[k] = des_pkg::SC_ABXA;
      else if (i != a && j == b) code_tab[k] = des_pkg::SC_ABXB;
      else if (i == a && j != b) code_tab[k] = des_pkg::SC_ABAY;
      else                       code_tab[k] = des_pkg::SC_ABAB;
      if (a == i) from_sent_tab[k] = count_up(from_sent_tab[k]);
      if (a == j) to_sent_tab[k] = count_up(to_sent_tab[k]);
      if (b == i) from_received_tab[k] = count_up(from_received_tab[k]);
      if (b == j) to_received_tab[k] = count_up(to_received_tab[k]);
      if (a == i && b == j) repeat_tab[k] = count_up(repeat_tab[k]);
      change_tab[k] = m;
      beat.pair_from     = i;
      beat.pair_to       = j;
      beat.shift_code    = code_tab[k];
      beat.from_sent     = 16'(from_sent_tab[k]);
      beat.to_sent       = 16'(to_sent_tab[k]);
      beat.from_received = 16'(from_received_tab[k]);
      beat.to_received   = 16'(to_received_tab[k]);
      beat.repeat_cnt    = 16'(repeat_tab[k]);
      beat.last_change   = change_tab[k];
      beat.last_of_event = last;
      return beat;
   endfunction

   // apply one event and queue the beats it should produce
   function automatic void apply_event(des_pkg::actor_type a, des_pkg::actor_type b,
                                       logic [15:0] m, bit typed,
                                       stats_beat_type typed_final);
      des_pkg::actor_type r;
      stats_beat_type     beat;
      // self events and actors out of range leave the table alone
      if (int'(a) >= des_pkg::ACTORS || int'(b) >= des_pkg::ACTORS || a == b)
         return;
      for (int k = 0; k < des_pkg::ACTORS; k++) begin
         r = des_pkg::actor_type'(k);
         if (r != a && r != b) begin
            queue_beat(refresh_pair(a, b, m, a, r, 1'b0));
            queue_beat(refresh_pair(a, b, m, r, a, 1'b0));
            queue_beat(refresh_pair(a, b, m, b, r, 1'b0));
            queue_beat(refresh_pair(a, b, m, r, b, 1'b0));
         end
      end
      queue_beat(refresh_pair(a, b, m, a, b, 1'b0));
      beat = refresh_pair(a, b, m, b, a, 1'b1);
      // hand-written final beat takes precedence where the table has one
      queue_beat(typed ? typed_final : beat);
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // event beats taken by the block drive the predictor
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         apply_event(req_event_sender, req_event_receiver, req_event_index,
                     offered_typed, offered_beat);
         events_taken <= events_taken + 1;
      end
   end

   // result beats are checked against the oldest pending one
   always @(posedge clock) begin : result_check
      stats_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_stats.size() == 0) begin
            $display("%0t: unexpected result beat for pair (%0d,%0d)",
                     $time, rsp_pair_from, rsp_pair_to);
            mismatch_count++;
         end else begin
            want = pending_stats.pop_front();
            check_field("pair_from", 16'(want.pair_from), 16'(rsp_pair_from));
            check_field("pair_to", 16'(want.pair_to), 16'(rsp_pair_to));
            check_field("shift_code", 16'(want.shift_code), 16'(rsp_shift_code));
            check_field("from_sent_total", want.from_sent, rsp_from_sent_total);
            check_field("to_sent_total", want.to_sent, rsp_to_sent_total);
            check_field("from_received_total", want.from_received,
                        rsp_from_received_total);
            check_field("to_received_total", want.to_received, rsp_to_received_total);
            check_field("repeat_total", want.repeat_cnt, rsp_repeat_total);
            check_field("last_change", want.last_change, rsp_last_change);
            check_field("final_of_run", 16'(want.last_of_event), 16'(rsp_final_of_run));
         end
      end
   end

   // sender: bursts of random length with random gaps, some bursts back to back
   initial begin : sender
      event_item_type item;
      int unsigned    burst_left;
      int unsigned    gap;
      bit             steady;
      req_valid          <= 1'b0;
      req_event_sender   <= '0;
      req_event_receiver <= '0;
      req_event_index    <= '0;
      offered_typed      <= 1'b0;
      offered_beat       <= NO_BEAT;
      do @(posedge clock); while (reset);
      burst_left = 0;
      while (event_q.size() > 0) begin
         if (burst_left == 0) begin
            steady     = ($urandom_range(0, 3) == 0);
            gap        = steady ? 0 : $urandom_range(1, 90);
            burst_left = steady ? $urandom_range(4, 20) : $urandom_range(1, 8);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         item = event_q.pop_front();
         burst_left--;
         req_valid          <= 1'b1;
         req_event_sender   <= item.sender;
         req_event_receiver <= item.receiver;
         req_event_index    <= item.index;
         offered_typed      <= item.typed;
         offered_beat       <= item.final_beat;
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;
   end

   // receiver: stall pattern in stretches, plus one long hold-off once random events start
   initial begin : receiver
      flow_mode_type mode;
      int unsigned   stretch_left;
      int unsigned   hold_left;
      int unsigned   tick;
      bit            hold_done;
      rsp_ready <= 1'b0;
      stretch_left = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
      tick         = 0;
      mode         = FLOW_OPEN;
      do @(posedge clock); while (reset);
      forever begin
         tick++;
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (!hold_done && events_taken >= DIR_N) begin
            rsp_ready <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
         end else begin
            if (stretch_left == 0) begin
               mode         = flow_mode_type'($urandom_range(0, 3));
               stretch_left = $urandom_range(20, 200);
            end
            stretch_left--;
            case (mode)
               FLOW_OPEN:   rsp_ready <= 1'b1;
               FLOW_HALF:   rsp_ready <= ($urandom_range(0, 1) == 1);
               FLOW_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:     rsp_ready <= (tick % 3 != 0);
            endcase
         end
         @(posedge clock);
      end
   end

   // stimulus build, reset and end of run
   initial begin : main
      des_pkg::actor_type cast_pool [4];
      des_pkg::actor_type s;
      des_pkg::actor_type r;
      logic [15:0]        seq;
      int unsigned        pick;
      int                 scene_left;
      int                 fresh;
      event_item_type     item;

      reset <= 1'b1;

      // directed: extreme actors and indexes, repeats, reversal, self events
      directed_rows = '{
         '{4'd0, 4'd15, 16'hFFFF, 1'b1,
           '{4'd15, 4'd0, des_pkg::SC_ABBA, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0,
             16'hFFFF, 1'b1}},
         '{4'd0, 4'd15, 16'h0000, 1'b1,
           '{4'd15, 4'd0, des_pkg::SC_ABBA, 16'd0, 16'd2, 16'd2, 16'd0, 16'd0,
             16'h0000, 1'b1}},
         '{4'd15, 4'd0, 16'h1234, 1'b1,
           '{4'd0, 4'd15, des_pkg::SC_ABBA, 16'd2, 16'd1, 16'd1, 16'd2, 16'd2,
             16'h1234, 1'b1}},
         '{4'd5,  4'd5,  16'h0005, 1'b0, NO_BEAT},
         '{4'd0,  4'd0,  16'hFFFF, 1'b0, NO_BEAT},
         '{4'd15, 4'd15, 16'h0000, 1'b0, NO_BEAT},
         '{4'd1,  4'd2,  16'h0007, 1'b0, NO_BEAT},
         '{4'd2,  4'd1,  16'h0008, 1'b0, NO_BEAT},
         '{4'd1,  4'd2,  16'h0009, 1'b0, NO_BEAT},
         '{4'd1,  4'd3,  16'h000A, 1'b0, NO_BEAT},
         '{4'd3,  4'd2,  16'h000B, 1'b0, NO_BEAT},
         '{4'd7,  4'd8,  16'h8000, 1'b0, NO_BEAT},
         '{4'd8,  4'd7,  16'h7FFF, 1'b0, NO_BEAT},
         '{4'd14, 4'd15, 16'h5555, 1'b0, NO_BEAT},
         '{4'd15, 4'd14, 16'hAAAA, 1'b0, NO_BEAT},
         '{4'd0,  4'd1,  16'h00FF, 1'b0, NO_BEAT},
         '{4'd10, 4'd5,  16'hFF00, 1'b0, NO_BEAT},
         '{4'd6,  4'd9,  16'h0F0F, 1'b0, NO_BEAT},
         '{4'd4,  4'd11, 16'hF0F0, 1'b0, NO_BEAT},
         '{4'd12, 4'd3,  16'h0013, 1'b0, NO_BEAT}
      };
      for (int k = 0; k < DIR_N; k++)
         queue_event(directed_rows[k]);

      // random: scenes among a small cast so counts build up, plus strays and self events
      seq        = 16'($urandom);
      scene_left = 0;
      fresh      = 0;
      while (fresh < RANDOM_EVENTS) begin
         if (scene_left == 0) begin
            for (int k = 0; k < 4; k++)
               cast_pool[k] = des_pkg::actor_type'($urandom_range(0, 15));
            scene_left = $urandom_range(5, 25);
         end
         scene_left--;
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            s = des_pkg::actor_type'($urandom_range(0, 15));
            r = s;
         end else if (pick < 70) begin
            s = cast_pool[$urandom_range(0, 3)];
            r = cast_pool[$urandom_range(0, 3)];
         end else begin
            s = des_pkg::actor_type'($urandom_range(0, 15));
            r = des_pkg::actor_type'($urandom_range(0, 15));
         end
         seq = ($urandom_range(0, 9) == 0) ? 16'($urandom) : seq + 16'd1;
         item.sender     = s;
         item.receiver   = r;
         item.index      = seq;
         item.typed      = 1'b0;
         item.final_beat = NO_BEAT;
         queue_event(item);
         fresh++;
      end
      total_events = event_q.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // drain: all events taken, all results seen, then a quiet tail
      while (events_taken < total_events) @(posedge clock);
      while (pending_stats.size() > 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
